// ----- hw/rtl/nrt_pkg.sv -----
package nrt_pkg;

	localparam int EGRESS_ENTRIES  = 1024;
	localparam int REVERSE_ENTRIES = 1024;

	// cells between pipeline registers on the match chains
	localparam int GROUP = 8;

	localparam int EGR_IW = $clog2(EGRESS_ENTRIES);
	localparam int EGR_CW = $clog2(EGRESS_ENTRIES + 1);
	localparam int REV_IW = $clog2(REVERSE_ENTRIES);
	localparam int REV_CW = $clog2(REVERSE_ENTRIES + 1);

	// cycles for a query to settle at the end of a chain
	localparam int EGR_WAIT = EGRESS_ENTRIES / GROUP + 3;
	localparam int REV_WAIT = REVERSE_ENTRIES / GROUP + 3;
	localparam int WAIT_W   = $clog2(((EGR_WAIT > REV_WAIT) ? EGR_WAIT : REV_WAIT) + 1);

	localparam logic [15:0] ETH_IPV4 = 16'h0800;
	localparam logic [7:0]  L4_TCP   = 8'd6;
	localparam logic [7:0]  L4_UDP   = 8'd17;

	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_EGR  = 2'd1;
	localparam logic [1:0] MODE_ING  = 2'd2;
	localparam logic [1:0] MODE_RSVD = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EGR,
		S_REV,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		C_PASS,
		C_LOAD,
		C_EGR,
		C_ING
	} class_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] ethertype;
		logic [7:0]  ip_protocol;
		logic        headers_complete;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] ip_checksum;
		logic [15:0] l4_checksum;
		logic [31:0] new_addr;
		logic [15:0] new_port;
	} in_item_t;

	typedef struct packed {
		logic        rewritten;
		logic        to_ingress;
		logic [31:0] out_src_addr;
		logic [31:0] out_dst_addr;
		logic [15:0] out_src_port;
		logic [15:0] out_dst_port;
		logic [15:0] out_ip_checksum;
		logic [15:0] out_l4_checksum;
		logic        status;
	} out_item_t;

	typedef struct packed {
		logic        en;
		logic        at_hit;
		logic [47:0] key;
		logic [47:0] tgt;
	} egr_wr_t;

	typedef struct packed {
		logic        en;
		logic        at_hit;
		logic [47:0] peer;
		logic [47:0] local_key;
		logic [47:0] orig;
	} rev_wr_t;

	// RFC 1624 eqn 3: replace an address and optionally a port
	function automatic logic [15:0] csum_upd(input logic [15:0] hc,
		input logic [31:0] old_a, input logic [31:0] new_a,
		input logic [15:0] old_p, input logic [15:0] new_p, input logic with_port);
		logic [18:0] s;
		logic [16:0] f;
		s = {3'b0, ~hc} + {3'b0, ~old_a[31:16]} + {3'b0, ~old_a[15:0]}
			+ {3'b0, new_a[31:16]} + {3'b0, new_a[15:0]};
		if (with_port) begin
			s = s + {3'b0, ~old_p} + {3'b0, new_p};
		end
		f = {1'b0, s[15:0]} + {14'b0, s[18:16]};
		f = {1'b0, f[15:0]} + {16'b0, f[16]};
		return ~f[15:0];
	endfunction

endpackage

// ----- hw/rtl/nrt_egr_cell.sv -----
module nrt_egr_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [nrt_pkg::EGR_IW-1:0]  idx,
	input  logic [nrt_pkg::EGR_CW-1:0]  cnt,
	input  logic [47:0]                 query,
	input  nrt_pkg::egr_wr_t            wr,
	input  logic                        hit_in,
	input  logic [47:0]                 tgt_in,
	output logic                        hit_out,
	output logic [47:0]                 tgt_out
);

	logic [47:0] key_q;
	logic [47:0] tgt_q;
	logic        match_q;
	logic        valid;
	logic        we;

	assign valid = {1'b0, idx} < cnt;
	assign we    = wr.en & (wr.at_hit ? match_q : ({1'b0, idx} == cnt));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else begin
			match_q <= valid & (key_q == query);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			key_q <= wr.key;
			tgt_q <= wr.tgt;
		end
	end

	// keys are unique, so at most one cell matches: OR is enough
	assign hit_out = hit_in | match_q;
	assign tgt_out = tgt_in | (match_q ? tgt_q : 48'b0);

endmodule

// ----- hw/rtl/nrt_rev_cell.sv -----
module nrt_rev_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [nrt_pkg::REV_IW-1:0]  idx,
	input  logic [nrt_pkg::REV_CW-1:0]  cnt,
	input  logic [95:0]                 query,
	input  nrt_pkg::rev_wr_t            wr,
	input  logic                        hit_in,
	input  logic [47:0]                 orig_in,
	output logic                        hit_out,
	output logic [47:0]                 orig_out
);

	logic [47:0] peer_q;
	logic [47:0] local_q;
	logic [47:0] orig_q;
	logic        match_q;
	logic        valid;
	logic        we;

	assign valid = {1'b0, idx} < cnt;
	assign we    = wr.en & (wr.at_hit ? match_q : ({1'b0, idx} == cnt));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else begin
			match_q <= valid & ({peer_q, local_q} == query);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			peer_q  <= wr.peer;
			local_q <= wr.local_key;
			orig_q  <= wr.orig;
		end
	end

	assign hit_out  = hit_in | match_q;
	assign orig_out = orig_in | (match_q ? orig_q : 48'b0);

endmodule

// ----- hw/rtl/nat_rewrite_with_reverse_table.sv -----
// Destination NAT with reverse table and incremental checksum update.
// Input channel in_valid/in_ready/in_data carries one parsed header or one
// egress table load; output channel out_valid/out_ready/out_data returns one
// result transaction per input transaction, in order.
// Each table is a chain of cells, one entry per cell. A query is broadcast,
// every cell registers its compare, and hit/data ripple down the chain with
// a register every 8 cells. Entries fill from the bottom by a fill count.
// One transaction is in flight at a time: in_ready is high only in the idle
// state. Pass-through items go straight to the final state; a load searches
// the egress table, an ingress packet the reverse table, and an egress packet
// the egress table and, on a hit, the reverse table. Each search waits for
// the match to settle at the end of its chain before the state moves on.
// A new transaction is taken while the previous result waits in the output
// register; if the receiver stalls, the next result waits in the final state
// and in_ready stays low. Reset empties both tables (fill counts to zero)
// and drops any pending result; no clearing pass is needed.
module nat_rewrite_with_reverse_table (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  nrt_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output nrt_pkg::out_item_t out_data
);

	nrt_pkg::state_t state_q, state_d;
	nrt_pkg::class_t class_q, class_d;
	nrt_pkg::in_item_t  item_q;
	nrt_pkg::out_item_t out_q, result;
	logic               out_valid_q;
	logic               out_load;

	logic [47:0] egr_query_q;
	logic [95:0] rev_query_q;
	logic [47:0] rw_q;
	logic        rew_q;
	logic        stat_q;
	logic [nrt_pkg::WAIT_W-1:0] wait_q;
	logic [nrt_pkg::EGR_CW-1:0] egr_cnt_q;
	logic [nrt_pkg::REV_CW-1:0] rev_cnt_q;

	nrt_pkg::egr_wr_t egr_wr;
	nrt_pkg::rev_wr_t rev_wr;
	logic             egr_full, rev_full;
	logic             ok;

	logic        egr_hit_c [nrt_pkg::EGRESS_ENTRIES+1];
	logic [47:0] egr_tgt_c [nrt_pkg::EGRESS_ENTRIES+1];
	logic        rev_hit_c [nrt_pkg::REVERSE_ENTRIES+1];
	logic [47:0] rev_org_c [nrt_pkg::REVERSE_ENTRIES+1];
	logic        egr_hit, rev_hit;
	logic [47:0] egr_tgt, rev_org;

	assign egr_hit_c[0] = 1'b0;
	assign egr_tgt_c[0] = 48'b0;
	assign rev_hit_c[0] = 1'b0;
	assign rev_org_c[0] = 48'b0;
	assign egr_hit = egr_hit_c[nrt_pkg::EGRESS_ENTRIES];
	assign egr_tgt = egr_tgt_c[nrt_pkg::EGRESS_ENTRIES];
	assign rev_hit = rev_hit_c[nrt_pkg::REVERSE_ENTRIES];
	assign rev_org = rev_org_c[nrt_pkg::REVERSE_ENTRIES];

	for (genvar g = 0; g < nrt_pkg::EGRESS_ENTRIES; g++) begin : g_egr
		logic        h_raw;
		logic [47:0] d_raw;
		nrt_egr_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (nrt_pkg::EGR_IW'(g)),
			.cnt     (egr_cnt_q),
			.query   (egr_query_q),
			.wr      (egr_wr),
			.hit_in  (egr_hit_c[g]),
			.tgt_in  (egr_tgt_c[g]),
			.hit_out (h_raw),
			.tgt_out (d_raw)
		);
		if (g % nrt_pkg::GROUP == nrt_pkg::GROUP - 1) begin : g_reg
			logic        h_q;
			logic [47:0] d_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					h_q <= 1'b0;
				end else begin
					h_q <= h_raw;
				end
			end
			always_ff @(posedge clk) begin
				d_q <= d_raw;
			end
			assign egr_hit_c[g+1] = h_q;
			assign egr_tgt_c[g+1] = d_q;
		end else begin : g_thru
			assign egr_hit_c[g+1] = h_raw;
			assign egr_tgt_c[g+1] = d_raw;
		end
	end

	for (genvar g = 0; g < nrt_pkg::REVERSE_ENTRIES; g++) begin : g_rev
		logic        h_raw;
		logic [47:0] d_raw;
		nrt_rev_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (nrt_pkg::REV_IW'(g)),
			.cnt      (rev_cnt_q),
			.query    (rev_query_q),
			.wr       (rev_wr),
			.hit_in   (rev_hit_c[g]),
			.orig_in  (rev_org_c[g]),
			.hit_out  (h_raw),
			.orig_out (d_raw)
		);
		if (g % nrt_pkg::GROUP == nrt_pkg::GROUP - 1) begin : g_reg
			logic        h_q;
			logic [47:0] d_q;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					h_q <= 1'b0;
				end else begin
					h_q <= h_raw;
				end
			end
			always_ff @(posedge clk) begin
				d_q <= d_raw;
			end
			assign rev_hit_c[g+1] = h_q;
			assign rev_org_c[g+1] = d_q;
		end else begin : g_thru
			assign rev_hit_c[g+1] = h_raw;
			assign rev_org_c[g+1] = d_raw;
		end
	end

	assign egr_full = (egr_cnt_q == nrt_pkg::EGR_CW'(nrt_pkg::EGRESS_ENTRIES));
	assign rev_full = (rev_cnt_q == nrt_pkg::REV_CW'(nrt_pkg::REVERSE_ENTRIES));

	assign ok = (in_data.ethertype == nrt_pkg::ETH_IPV4) && in_data.headers_complete &&
		((in_data.ip_protocol == nrt_pkg::L4_TCP) ||
		 (in_data.ip_protocol == nrt_pkg::L4_UDP));

	always_comb begin
		if (in_data.mode == nrt_pkg::MODE_LOAD) begin
			class_d = nrt_pkg::C_LOAD;
		end else if (ok && in_data.mode == nrt_pkg::MODE_EGR) begin
			class_d = nrt_pkg::C_EGR;
		end else if (ok && in_data.mode == nrt_pkg::MODE_ING) begin
			class_d = nrt_pkg::C_ING;
		end else begin
			class_d = nrt_pkg::C_PASS;
		end
	end

	always_comb begin
		state_d          = state_q;
		in_ready         = 1'b0;
		out_load         = 1'b0;
		egr_wr.en        = 1'b0;
		egr_wr.at_hit    = egr_hit;
		egr_wr.key       = {item_q.dst_addr, item_q.dst_port};
		egr_wr.tgt       = {item_q.new_addr, item_q.new_port};
		rev_wr.en        = 1'b0;
		rev_wr.at_hit    = rev_hit;
		rev_wr.peer      = rev_query_q[95:48];
		rev_wr.local_key = rev_query_q[47:0];
		rev_wr.orig      = {item_q.dst_addr, item_q.dst_port};
		case (state_q)
			nrt_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (class_d)
						nrt_pkg::C_PASS: state_d = nrt_pkg::S_DONE;
						nrt_pkg::C_ING:  state_d = nrt_pkg::S_REV;
						default:         state_d = nrt_pkg::S_EGR;
					endcase
				end
			end
			nrt_pkg::S_EGR: begin
				if (wait_q == '0) begin
					if (class_q == nrt_pkg::C_LOAD) begin
						egr_wr.en = egr_hit | ~egr_full;
						state_d   = nrt_pkg::S_DONE;
					end else if (egr_hit) begin
						state_d = nrt_pkg::S_REV;
					end else begin
						state_d = nrt_pkg::S_DONE;
					end
				end
			end
			nrt_pkg::S_REV: begin
				if (wait_q == '0) begin
					if (class_q == nrt_pkg::C_EGR) begin
						rev_wr.en = rev_hit | ~rev_full;
					end
					state_d = nrt_pkg::S_DONE;
				end
			end
			nrt_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = nrt_pkg::S_IDLE;
				end
			end
			default: state_d = nrt_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nrt_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			egr_cnt_q   <= '0;
			rev_cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (egr_wr.en && !egr_wr.at_hit) begin
				egr_cnt_q <= egr_cnt_q + nrt_pkg::EGR_CW'(1);
			end
			if (rev_wr.en && !rev_wr.at_hit) begin
				rev_cnt_q <= rev_cnt_q + nrt_pkg::REV_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			nrt_pkg::S_IDLE: begin
				if (in_valid) begin
					item_q      <= in_data;
					class_q     <= class_d;
					egr_query_q <= {in_data.dst_addr, in_data.dst_port};
					rev_query_q <= {in_data.src_addr, in_data.src_port,
						in_data.dst_addr, in_data.dst_port};
					wait_q      <= (class_d == nrt_pkg::C_ING) ?
						nrt_pkg::WAIT_W'(nrt_pkg::REV_WAIT) :
						nrt_pkg::WAIT_W'(nrt_pkg::EGR_WAIT);
					rew_q       <= 1'b0;
					stat_q      <= 1'b0;
				end
			end
			nrt_pkg::S_EGR: begin
				if (wait_q == '0) begin
					if (class_q == nrt_pkg::C_LOAD) begin
						stat_q <= ~egr_hit & egr_full;
					end else if (egr_hit) begin
						rw_q        <= egr_tgt;
						rew_q       <= 1'b1;
						rev_query_q <= {egr_tgt, item_q.src_addr, item_q.src_port};
						wait_q      <= nrt_pkg::WAIT_W'(nrt_pkg::REV_WAIT);
					end
				end else begin
					wait_q <= wait_q - nrt_pkg::WAIT_W'(1);
				end
			end
			nrt_pkg::S_REV: begin
				if (wait_q == '0) begin
					if (class_q == nrt_pkg::C_EGR) begin
						stat_q <= ~rev_hit & rev_full;
					end else if (rev_hit) begin
						rw_q  <= rev_org;
						rew_q <= 1'b1;
					end
				end else begin
					wait_q <= wait_q - nrt_pkg::WAIT_W'(1);
				end
			end
			nrt_pkg::S_DONE: begin
				if (out_load) begin
					out_q <= result;
				end
			end
			default: ;
		endcase
	end

	// ingress rewrites the source, egress the destination
	always_comb begin
		logic        ing;
		logic [31:0] old_a;
		logic [15:0] old_p;
		ing   = rew_q & (class_q == nrt_pkg::C_ING);
		old_a = ing ? item_q.src_addr : item_q.dst_addr;
		old_p = ing ? item_q.src_port : item_q.dst_port;
		result.rewritten       = rew_q;
		result.to_ingress      = ing;
		result.out_src_addr    = ing ? rw_q[47:16] : item_q.src_addr;
		result.out_src_port    = ing ? rw_q[15:0]  : item_q.src_port;
		result.out_dst_addr    = (rew_q && !ing) ? rw_q[47:16] : item_q.dst_addr;
		result.out_dst_port    = (rew_q && !ing) ? rw_q[15:0]  : item_q.dst_port;
		result.out_ip_checksum = rew_q ? nrt_pkg::csum_upd(item_q.ip_checksum, old_a,
			rw_q[47:16], 16'b0, 16'b0, 1'b0) : item_q.ip_checksum;
		result.out_l4_checksum = rew_q ? nrt_pkg::csum_upd(item_q.l4_checksum, old_a,
			rw_q[47:16], old_p, rw_q[15:0], 1'b1) : item_q.l4_checksum;
		result.status          = stat_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_egr_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		egr_cnt_q <= nrt_pkg::EGR_CW'(nrt_pkg::EGRESS_ENTRIES))
		else $error("egress fill count overflow");

	a_rev_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rev_cnt_q <= nrt_pkg::REV_CW'(nrt_pkg::REVERSE_ENTRIES))
		else $error("reverse fill count overflow");

	a_idle_no_egr_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nrt_pkg::S_IDLE) |=> (egr_cnt_q == $past(egr_cnt_q)))
		else $error("egress table written while idle");

	a_rev_write_from_egr: assert property (@(posedge clk) disable iff (!arst_n)
		rev_wr.en |-> (class_q == nrt_pkg::C_EGR && rew_q))
		else $error("reverse insert without egress hit");

	a_load_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nrt_pkg::S_DONE && out_valid_q && !out_ready) |=>
		(state_q == nrt_pkg::S_DONE))
		else $error("result dropped under stall");

endmodule
